// ----- rtl/joystick_type_detect_debounce_macros.svh -----
// Assertion helpers used by the file that checks the block.
`ifndef JOYSTICK_TYPE_DETECT_DEBOUNCE_MACROS_SVH
`define JOYSTICK_TYPE_DETECT_DEBOUNCE_MACROS_SVH

// Check that a condition in one cycle brings a consequence in the next one.
`define JTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that a condition holds together with its consequence in the same cycle.
`define JTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/jtd_pkg.sv -----
`default_nettype none

package jtd_pkg;

    localparam int NUM_PORTS   = 2;
    localparam int SAMPLE_BITS = 10;

    localparam int IDX_W      = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int THR_W      = 10;
    localparam int CNT_W      = 8;
    localparam int CMP_W      = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [THR_W-1:0]       thr_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [IDX_W-1:0]       idx_t;

    localparam sample_t SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
    localparam cnt_t    CNT_MAX    = {CNT_W{1'b1}};

    // Item operation codes; the fourth code is unused.
    typedef enum logic [1:0] {
        OP_X        = 2'd0,
        OP_XR       = 2'd1,
        OP_CONCLUDE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        TYPE_NONE   = 2'd0,
        TYPE_14B    = 2'd1,
        TYPE_SINGLE = 2'd2,
        TYPE_TWIN   = 2'd3
    } jtype_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE   = 2'd0,
        CFG_MATCH   = 2'd1,
        CFG_CONFIRM = 2'd2
    } cfg_reg_t;

    localparam thr_t RANGE_RESET   = 10'd20;
    localparam thr_t MATCH_RESET   = 10'd10;
    localparam cnt_t CONFIRM_RESET = 8'd3;

    // One port's state, one memory word.
    typedef struct packed {
        jtype_t  confirmed;
        jtype_t  pending;
        cnt_t    agree_count;
        sample_t x_min;
        sample_t x_max;
        sample_t xr_min;
        sample_t xr_max;
        logic    seen_x;
        logic    seen_xr;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{
        confirmed:   TYPE_NONE,
        pending:     TYPE_NONE,
        agree_count: '0,
        x_min:       SAMPLE_MAX,
        x_max:       '0,
        xr_min:      SAMPLE_MAX,
        xr_max:      '0,
        seen_x:      1'b0,
        seen_xr:     1'b0
    };

endpackage

`default_nettype wire

// ----- rtl/jtd_item_if.sv -----
`default_nettype none

interface jtd_item_if;
    import jtd_pkg::*;

    logic    valid;
    logic    ready;
    logic    port;
    logic [1:0] operation;
    sample_t sample;
    logic    pin5_grounded;
    sample_t x_value;
    sample_t xr_value;

    modport source (
        output valid, port, operation, sample, pin5_grounded, x_value, xr_value,
        input  ready
    );
    modport sink (
        input  valid, port, operation, sample, pin5_grounded, x_value, xr_value,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/jtd_result_if.sv -----
`default_nettype none

interface jtd_result_if;
    import jtd_pkg::*;

    logic   valid;
    logic   ready;
    jtype_t confirmed_type;
    jtype_t raw_type;

    modport source (
        output valid, confirmed_type, raw_type,
        input  ready
    );
    modport sink (
        input  valid, confirmed_type, raw_type,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/jtd_cfg_if.sv -----
`default_nettype none

interface jtd_cfg_if;
    import jtd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/joystick_type_detect_debounce.sv -----
// Channel  Modport  Payload
// item     sink     port, operation, sample, pin5_grounded, x_value, xr_value
// result   source   confirmed_type, raw_type
// cfg      sink     index, data
//
// One item per cycle. A conclude request is registered in the update stage and
// its result then in the output register; the per-port state memory is read on
// acceptance and written back when the update stage fires, pending updates being
// forwarded to a request for the same port. A conclude holds in the update stage
// while the output register is full and not taken, and the item channel stalls
// behind it. Reset is asynchronous; per-port valid bits make every entry read as
// its reset value until first written. Config writes are taken in every cycle.
`default_nettype none
`include "joystick_type_detect_debounce_macros.svh"

module joystick_type_detect_debounce (
    input  wire        clk,
    input  wire        rst_n,
    jtd_item_if.sink   item,
    jtd_result_if.source result,
    jtd_cfg_if.sink    cfg
);
    import jtd_pkg::*;

    // Configuration registers
    thr_t range_thr_reg;
    thr_t match_thr_reg;
    cnt_t confirm_reg;

    // State memory and its valid bits
    entry_t state_mem [NUM_PORTS];
    logic   entry_valid_reg [NUM_PORTS];

    // Read side
    entry_t rd_mem_reg;
    logic   rd_valid_reg;
    logic   fwd_reg;
    entry_t fwd_data_reg;

    // Update stage
    logic       s1_valid_reg;
    logic [1:0] s1_op_reg;
    idx_t       s1_idx_reg;
    logic       s1_pin5_reg;
    sample_t    s1_sample_reg;
    sample_t    s1_xv_reg;
    sample_t    s1_xrv_reg;

    // Output register
    logic   out_valid_reg;
    logic   out_valid_next;
    jtype_t out_conf_reg;
    jtype_t out_raw_reg;

    logic   item_accept;
    logic   item_take;
    logic   port_ok;
    logic   op_used;
    idx_t   in_idx;
    logic   s1_is_result;
    logic   s1_fire;
    logic   out_free;
    entry_t cur;
    entry_t nxt;
    jtype_t raw;
    logic   x_unstable;
    logic   xr_unstable;
    sample_t val_diff;
    cnt_t   cnt_inc;

    // Handshake
    assign cfg.ready     = 1'b1;
    assign out_free      = !out_valid_reg || result.ready;
    assign s1_is_result  = (s1_op_reg == OP_CONCLUDE);
    assign s1_fire       = s1_valid_reg && (!s1_is_result || out_free);
    assign item.ready    = !s1_valid_reg || s1_fire;
    assign item_accept   = item.valid && item.ready;
    assign in_idx        = idx_t'(item.port);
    assign port_ok       = (32'(item.port) < 32'(NUM_PORTS));
    assign op_used       = (item.operation == OP_X) || (item.operation == OP_XR)
                           || (item.operation == OP_CONCLUDE);
    assign item_take     = item_accept && port_ok && op_used;

    // Take config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_thr_reg <= RANGE_RESET;
            match_thr_reg <= MATCH_RESET;
            confirm_reg   <= CONFIRM_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_RANGE:   range_thr_reg <= thr_t'(cfg.data);
                CFG_MATCH:   match_thr_reg <= thr_t'(cfg.data);
                CFG_CONFIRM: confirm_reg   <= cfg.data[CNT_W-1:0];
                default:     ;
            endcase
        end
    end

    // Read the entry of an accepted request, write back the finished update
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            state_mem[s1_idx_reg] <= nxt;
        end
        if (item_take)
        begin
            rd_mem_reg <= state_mem[in_idx];
        end
    end

    // Track written entries and forward an update for the same port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                entry_valid_reg[s1_idx_reg] <= 1'b1;
            end
            if (item_take)
            begin
                rd_valid_reg <= entry_valid_reg[in_idx];
                fwd_reg      <= s1_fire && (s1_idx_reg == in_idx);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            fwd_data_reg <= nxt;
        end
    end

    // Advance the update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_op_reg     <= item.operation;
            s1_idx_reg    <= in_idx;
            s1_pin5_reg   <= item.pin5_grounded;
            s1_sample_reg <= item.sample;
            s1_xv_reg     <= item.x_value;
            s1_xrv_reg    <= item.xr_value;
        end
    end

    // Pick the current entry
    always_comb
    begin
        if (fwd_reg)
            cur = fwd_data_reg;
        else if (rd_valid_reg)
            cur = rd_mem_reg;
        else
            cur = RESET_ENTRY;
    end

    // Classify the round
    always_comb
    begin
        x_unstable  = !cur.seen_x || (cur.x_max < cur.x_min)
                      || (CMP_W'(cur.x_max - cur.x_min) > CMP_W'(range_thr_reg));
        xr_unstable = !cur.seen_xr || (cur.xr_max < cur.xr_min)
                      || (CMP_W'(cur.xr_max - cur.xr_min) > CMP_W'(range_thr_reg));
        val_diff    = (s1_xv_reg > s1_xrv_reg) ? (s1_xv_reg - s1_xrv_reg)
                                               : (s1_xrv_reg - s1_xv_reg);
        if (x_unstable)
            raw = TYPE_NONE;
        else if (s1_pin5_reg)
            raw = TYPE_TWIN;
        else if (xr_unstable)
            raw = TYPE_14B;
        else if (CMP_W'(val_diff) <= CMP_W'(match_thr_reg))
            raw = TYPE_SINGLE;
        else
            raw = TYPE_14B;
    end

    // Update trackers or debounce and clear
    always_comb
    begin
        nxt     = cur;
        cnt_inc = (cur.agree_count == CNT_MAX) ? cur.agree_count
                                               : cur.agree_count + cnt_t'(1);
        case (s1_op_reg)
            OP_X:
            begin
                if (s1_sample_reg < cur.x_min)
                    nxt.x_min = s1_sample_reg;
                if (s1_sample_reg > cur.x_max)
                    nxt.x_max = s1_sample_reg;
                nxt.seen_x = 1'b1;
            end
            OP_XR:
            begin
                if (s1_sample_reg < cur.xr_min)
                    nxt.xr_min = s1_sample_reg;
                if (s1_sample_reg > cur.xr_max)
                    nxt.xr_max = s1_sample_reg;
                nxt.seen_xr = 1'b1;
            end
            OP_CONCLUDE:
            begin
                if (raw == cur.confirmed)
                begin
                    nxt.pending     = cur.confirmed;
                    nxt.agree_count = '0;
                end
                else if (raw == cur.pending)
                begin
                    nxt.agree_count = cnt_inc;
                    if (cnt_inc >= confirm_reg)
                    begin
                        // Move between joystick types only by way of none
                        if (cur.confirmed != TYPE_NONE && raw != TYPE_NONE)
                        begin
                            nxt.confirmed = TYPE_NONE;
                        end
                        else
                        begin
                            nxt.confirmed   = raw;
                            nxt.pending     = raw;
                            nxt.agree_count = '0;
                        end
                    end
                end
                else
                begin
                    nxt.pending     = raw;
                    nxt.agree_count = cnt_t'(1);
                end
                nxt.x_min   = SAMPLE_MAX;
                nxt.x_max   = '0;
                nxt.xr_min  = SAMPLE_MAX;
                nxt.xr_max  = '0;
                nxt.seen_x  = 1'b0;
                nxt.seen_xr = 1'b0;
            end
            default: ;
        endcase
    end

    // Load or drain the output register
    always_comb
    begin
        if (s1_fire && s1_is_result)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_is_result)
        begin
            out_conf_reg <= nxt.confirmed;
            out_raw_reg  <= raw;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.confirmed_type = out_conf_reg;
    assign result.raw_type       = out_raw_reg;

    // Checks
    `JTD_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s1_fire, s1_valid_reg,
        "update stage dropped a stalled request")
    `JTD_ASSERT_NEXT(a_result_load, clk, rst_n, s1_fire && s1_is_result, out_valid_reg,
        "conclude request gave no result")
    `JTD_ASSERT_NOW(a_ready_stall, clk, rst_n, !item.ready, s1_valid_reg && s1_is_result,
        "item channel stalled without a waiting conclude")

endmodule

`default_nettype wire
